FILE: src/awc_pkg.sv
package awc_pkg;

	localparam int ALPHABET = 26;
	localparam int LETTER_W = 5;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 16;
	localparam int NZ_W     = $clog2(ALPHABET + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Command codes carried on the input tuser.
	localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

	// Status codes carried on the output tuser.
	localparam logic [STATUS_W-1:0] ST_PATTERN  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TEXT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

	typedef logic [LETTER_W-1:0] letter_t;

	// One update of the difference bank: at most one increment and one decrement.
	typedef struct packed {
		logic    commit;
		logic    clear;
		logic    inc_en;
		letter_t inc_letter;
		logic    dec_en;
		letter_t dec_letter;
	} diff_upd_t;

endpackage

FILE: src/awc_diff_bank.sv
module awc_diff_bank #(
	parameter int DIFF_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  awc_pkg::diff_upd_t    upd,
	output logic [awc_pkg::NZ_W-1:0] nz_next
);
	import awc_pkg::*;

	logic signed [DIFF_W-1:0] diff_q [ALPHABET];
	logic [NZ_W-1:0]          nz_q;

	logic [ALPHABET-1:0] only_inc, only_dec, is_zero, is_plus1, is_minus1;
	logic [1:0]          gain, lose;

	// Each lane recognizes its own letter, so no array is read at a chosen index.
	for (genvar i = 0; i < ALPHABET; i++) begin : g_lane
		logic inc_hit, dec_hit;
		assign inc_hit      = upd.inc_en && (upd.inc_letter == LETTER_W'(i));
		assign dec_hit      = upd.dec_en && (upd.dec_letter == LETTER_W'(i));
		assign only_inc[i]  = inc_hit && !dec_hit;
		assign only_dec[i]  = dec_hit && !inc_hit;
		assign is_zero[i]   = (diff_q[i] == '0);
		assign is_plus1[i]  = (diff_q[i] == DIFF_W'(1));
		assign is_minus1[i] = (diff_q[i] == '1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				diff_q[i] <= '0;
			end else if (upd.commit) begin
				if (upd.clear) begin
					diff_q[i] <= '0;
				end else if (only_inc[i]) begin
					diff_q[i] <= diff_q[i] + DIFF_W'(1);
				end else if (only_dec[i]) begin
					diff_q[i] <= diff_q[i] - DIFF_W'(1);
				end
			end
		end
	end

	// Only two lanes can change, so the nonzero count moves by at most two.
	assign gain = {1'b0, |(only_inc & is_zero)} + {1'b0, |(only_dec & is_zero)};
	assign lose = {1'b0, |(only_inc & is_minus1)} + {1'b0, |(only_dec & is_plus1)};

	always_comb begin
		if (upd.clear) begin
			nz_next = '0;
		end else begin
			nz_next = nz_q + NZ_W'(gain) - NZ_W'(lose);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (upd.commit) begin
			nz_q <= nz_next;
		end
	end

endmodule

FILE: src/anagram_window_counter.sv
// Channel  | Dir | Signals                         | Contents
// s_axis   | in  | tvalid tready tdata[7:0] tuser  | tdata: letter; tuser: command
// m_axis   | out | tvalid tready tdata[23:0] tuser | tdata: window_full, match, count;
//          |     |                                 | tuser: status
//
// Every accepted transfer is finished in the cycle it is taken: the difference bank,
// the window counters and the ring are updated at that edge and the result is
// loaded into the output register, so one letter per cycle is sustained while m_axis is not stalled.
// The ring is a single-port-write memory whose read of the oldest letter is
// registered ahead of use, at the pointer value being written back.
// Reset clears all control state at once; the ring needs no clearing pass.
// A new transfer is taken while the output register is empty or being drained.
module anagram_window_counter #(
	parameter int MAX_PATTERN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [4:0] letter, [7:5] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [0] window_full, [1] match, [17:2] match_count
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import awc_pkg::*;

	// Length counters must hold MAX_PATTERN itself; the ring pointer indexes the ring.
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int DIFF_W = LEN_W + 1;

	logic [CMD_W-1:0] command;
	letter_t          letter;
	logic             accept;

	assign command = s_axis_tuser;
	assign letter  = s_axis_tdata[LETTER_W-1:0];
	assign accept  = s_axis_tvalid && s_axis_tready;

	// Window state.
	logic [LEN_W-1:0] pattern_len_q, fill_q;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic             text_started_q;
	logic [COUNT_W-1:0] matches_q;

	// Ring of the last text letters, with a registered read ahead of use.
	letter_t          ring_mem [MAX_PATTERN];
	letter_t          ring_rd_q, byp_data_q, oldest;
	logic             byp_q;
	logic             ring_we;

	// Output register.
	logic               out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic               out_full_q, out_match_q;
	logic [COUNT_W-1:0] out_count_q;

	diff_upd_t        upd;
	logic [NZ_W-1:0]  nz_next;

	awc_diff_bank #(.DIFF_W(DIFF_W)) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.nz_next(nz_next)
	);

	// Decode of the accepted transfer.
	logic letter_ok, is_clear, pat_ok, text_ok, text_store, window_drop, full_now, hit;
	logic [LEN_W-1:0] ptr_ext, ptr_inc;
	logic [PTR_W-1:0] ptr_wrap;
	logic [STATUS_W-1:0] status_d;
	logic [COUNT_W-1:0]  matches_d;

	assign letter_ok  = (letter < LETTER_W'(ALPHABET));
	assign is_clear   = (command == CMD_CLEAR);
	assign pat_ok     = (command == CMD_PATTERN) && letter_ok && !text_started_q &&
	                    (pattern_len_q < LEN_W'(MAX_PATTERN));
	assign text_ok    = (command == CMD_TEXT) && letter_ok;
	assign text_store = text_ok && (pattern_len_q != '0);

	// Once the window is full the slot at the pointer holds the oldest letter.
	assign window_drop = (fill_q >= pattern_len_q);
	assign full_now    = window_drop || (fill_q + LEN_W'(1) == pattern_len_q);
	assign hit         = text_store && full_now && (nz_next == '0);
	assign oldest      = byp_q ? byp_data_q : ring_rd_q;

	assign ptr_ext  = LEN_W'(ptr_q);
	assign ptr_inc  = ptr_ext + LEN_W'(1);
	assign ptr_wrap = (ptr_inc >= pattern_len_q) ? '0 : PTR_W'(ptr_inc);

	always_comb begin
		upd            = '0;
		upd.commit     = accept;
		upd.clear      = is_clear;
		upd.inc_en     = pat_ok || (text_store && window_drop);
		upd.inc_letter = pat_ok ? letter : oldest;
		upd.dec_en     = text_store;
		upd.dec_letter = letter;
	end

	always_comb begin
		if (is_clear) begin
			status_d = ST_CLEARED;
		end else if (pat_ok) begin
			status_d = ST_PATTERN;
		end else if (text_ok) begin
			status_d = ST_TEXT;
		end else begin
			status_d = ST_REJECTED;
		end
	end

	always_comb begin
		if (is_clear) begin
			matches_d = '0;
		end else if (hit && matches_q != COUNT_MAX) begin
			matches_d = matches_q + COUNT_W'(1);
		end else begin
			matches_d = matches_q;
		end
	end

	// The pointer value after this cycle also addresses the look-ahead read.
	always_comb begin
		if (accept && is_clear) begin
			ptr_d = '0;
		end else if (accept && text_store) begin
			ptr_d = ptr_wrap;
		end else begin
			ptr_d = ptr_q;
		end
	end

	assign ring_we = accept && text_store;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ptr_q] <= letter;
		end
	end

	always_ff @(posedge clk) begin
		ring_rd_q  <= ring_mem[ptr_d];
		byp_data_q <= letter;
	end

	// A one-letter pattern reads back the slot it is writing in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= ring_we && (ptr_d == ptr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q  <= '0;
			fill_q         <= '0;
			ptr_q          <= '0;
			text_started_q <= 1'b0;
			matches_q      <= '0;
		end else begin
			ptr_q <= ptr_d;
			if (accept) begin
				matches_q <= matches_d;
				if (is_clear) begin
					pattern_len_q  <= '0;
					fill_q         <= '0;
					text_started_q <= 1'b0;
				end else if (pat_ok) begin
					pattern_len_q <= pattern_len_q + LEN_W'(1);
				end else if (text_ok) begin
					text_started_q <= 1'b1;
					if (text_store && !window_drop) begin
						fill_q <= fill_q + LEN_W'(1);
					end
				end
			end
		end
	end

	// Output register; it takes a new result whenever it is empty or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_d;
			out_full_q   <= text_store && full_now;
			out_match_q  <= hit;
			out_count_q  <= matches_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {6'd0, out_count_q, out_match_q, out_full_q};

endmodule

FILE: src/awc_checker.sv
module awc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import awc_pkg::*;

	logic               out_xfer;
	logic [COUNT_W-1:0] last_count_q;
	logic [COUNT_W-1:0] count;

	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign count    = m_axis_tdata[17:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (out_xfer) begin
			last_count_q <= count;
		end
	end

	// A match is only reported on a full window of a text letter.
	a_match_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && m_axis_tuser == ST_TEXT)
		else $error("match without a full text window");

	// Non-text results carry no window flags; a clear also zeroes the count.
	a_non_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_TEXT |-> m_axis_tdata[1:0] == 2'b00 &&
		(m_axis_tuser != ST_CLEARED || count == '0))
		else $error("window flags or count wrong on a non-text result");

	// The count steps by one on each match, saturating at COUNT_MAX, and otherwise holds, until a clear.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && m_axis_tuser != ST_CLEARED |->
		(m_axis_tdata[1] && last_count_q != COUNT_MAX) ?
		count == last_count_q + COUNT_W'(1) : count == last_count_q)
		else $error("match count does not follow the reported matches");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind anagram_window_counter awc_checker u_awc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
